/* design/pewb_pkg.sv */
// Shared types, register codes, reset values and saturation helper for the particle step block.
`timescale 1ns / 1ps
`default_nettype none

package pewb_pkg;

	// One particle going in.
	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic [15:0]        delta_time;
	} in_item_t;

	// One particle coming out.
	typedef struct packed {
		logic signed [31:0] new_pos_x;
		logic signed [31:0] new_pos_y;
		logic signed [31:0] new_pos_z;
		logic signed [31:0] new_vel_x;
		logic signed [31:0] new_vel_y;
		logic signed [31:0] new_vel_z;
	} out_item_t;

	// Stage advance strobes handed to the wall stages.
	typedef struct packed {
		logic en_s3;
		logic en_s4;
	} pipe_ctl_t;

	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_SCENE_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCENE_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_X     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_Y     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_Z     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BOUNCE_FACTOR = 3'd5;

	localparam logic [30:0]        RST_SCENE_WIDTH   = 31'd3276800;
	localparam logic [30:0]        RST_SCENE_HEIGHT  = 31'd2457600;
	localparam logic signed [31:0] RST_GRAVITY_X     = 32'sd0;
	localparam logic signed [31:0] RST_GRAVITY_Y     = 32'sd0;
	localparam logic signed [31:0] RST_GRAVITY_Z     = -32'sd4014080;
	localparam logic [15:0]        RST_BOUNCE_FACTOR = 16'd26214;

	localparam logic signed [34:0] SAT_MAX = 35'sd2147483647;
	localparam logic signed [34:0] SAT_MIN = -35'sd2147483648;

	// Clamp a wide signed value into the signed 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
		logic signed [31:0] r;
		if (v > SAT_MAX) begin
			r = 32'sh7FFFFFFF;
		end else if (v < SAT_MIN) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* design/pewb_wall.sv */
// Wall test, clamp and bounce velocity for one bounded axis (pipeline stages 3 and 4).
`timescale 1ns / 1ps
`default_nettype none

module pewb_wall (
	input  wire logic               clk,
	input  wire pewb_pkg::pipe_ctl_t ctl,
	input  wire logic signed [31:0] pos_s2,
	input  wire logic signed [31:0] vel_s2,
	input  wire logic [29:0]        half,
	input  wire logic [15:0]        bounce,
	output logic signed [31:0]      pos_s4,
	output logic signed [31:0]      vel_s4
);

	logic signed [32:0] pos_ext;
	logic signed [32:0] half_pos;
	logic signed [32:0] half_neg;
	logic signed [32:0] vel_neg;
	logic               below;
	logic               above;

	logic signed [31:0] pos_s3;
	logic signed [31:0] vel_s3;
	logic signed [49:0] prod_s3;
	logic               hit_s3;

	logic signed [49:0] rnd;

	always_comb begin
		pos_ext  = {pos_s2[31], pos_s2};
		half_pos = $signed({3'b000, half});
		half_neg = -half_pos;
		below    = pos_ext < half_neg;
		above    = pos_ext > half_pos;
		// Negating in 33 bits keeps the most negative velocity exact.
		vel_neg  = -$signed({vel_s2[31], vel_s2});
	end

	// Stage 3: compare against both walls while the bounce product is formed.
	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			hit_s3  <= below | above;
			pos_s3  <= below ? half_neg[31:0] : (above ? half_pos[31:0] : pos_s2);
			vel_s3  <= vel_s2;
			prod_s3 <= vel_neg * $signed({1'b0, bounce});
		end
	end

	// Round half up, then floor by the upper bits.
	assign rnd = prod_s3 + 50'sd16384;

	// Stage 4: rounded and saturated bounce velocity on a hit.
	always_ff @(posedge clk) begin
		if (ctl.en_s4) begin
			pos_s4 <= pos_s3;
			vel_s4 <= hit_s3 ? pewb_pkg::sat32(rnd[49:15]) : vel_s3;
		end
	end

endmodule

`default_nettype wire

/* design/particle_euler_step_wall_bounce_top.sv */
// An accepted item passes through four register stages (s1 to s4) before it appears at out_valid.
// Throughput: one item per cycle; a stall on the output holds every full stage without loss.
// Stage 1 multiplies by the time step, stage 2 rounds, adds and saturates, stage 3 tests
// the walls and forms the bounce product, stage 4 rounds and saturates the bounce.
// Reset clears all stage valid bits and loads the default box, gravity and bounce values.
`timescale 1ns / 1ps
`default_nettype none

module particle_euler_step_wall_bounce_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire pewb_pkg::in_item_t               in_item,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output pewb_pkg::out_item_t                   out_item,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [pewb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [31:0]                      cfg_data
);

	localparam int LANES = 6;

	logic [30:0]        scene_width_q;
	logic [30:0]        scene_height_q;
	logic signed [31:0] gravity_x_q;
	logic signed [31:0] gravity_y_q;
	logic signed [31:0] gravity_z_q;
	logic [15:0]        bounce_factor_q;

	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;
	pewb_pkg::pipe_ctl_t ctl;

	logic signed [31:0] rate_w [LANES];
	logic signed [31:0] base_w [LANES];
	logic signed [48:0] rnd_w  [LANES];
	logic signed [33:0] sum_w  [LANES];

	logic signed [48:0] prod_s1 [LANES];
	logic signed [31:0] base_s1 [LANES];
	logic signed [31:0] res_s2  [LANES];

	logic signed [31:0] pos_y_s3, vel_y_s3;
	logic signed [31:0] pos_y_s4, vel_y_s4;
	logic signed [31:0] pos_x_s4, vel_x_s4;
	logic signed [31:0] pos_z_s4, vel_z_s4;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scene_width_q   <= pewb_pkg::RST_SCENE_WIDTH;
			scene_height_q  <= pewb_pkg::RST_SCENE_HEIGHT;
			gravity_x_q     <= pewb_pkg::RST_GRAVITY_X;
			gravity_y_q     <= pewb_pkg::RST_GRAVITY_Y;
			gravity_z_q     <= pewb_pkg::RST_GRAVITY_Z;
			bounce_factor_q <= pewb_pkg::RST_BOUNCE_FACTOR;
		end else if (cfg_valid) begin
			case (cfg_index)
				pewb_pkg::REG_SCENE_WIDTH:   scene_width_q   <= cfg_data[30:0];
				pewb_pkg::REG_SCENE_HEIGHT:  scene_height_q  <= cfg_data[30:0];
				pewb_pkg::REG_GRAVITY_X:     gravity_x_q     <= $signed(cfg_data);
				pewb_pkg::REG_GRAVITY_Y:     gravity_y_q     <= $signed(cfg_data);
				pewb_pkg::REG_GRAVITY_Z:     gravity_z_q     <= $signed(cfg_data);
				pewb_pkg::REG_BOUNCE_FACTOR: bounce_factor_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// A stage moves on when it is empty or the stage after it moves on.
	assign en_s4     = !v_s4 || out_ready;
	assign en_s3     = !v_s3 || en_s4;
	assign en_s2     = !v_s2 || en_s3;
	assign en_s1     = !v_s1 || en_s2;
	assign in_ready  = en_s1;
	assign out_valid = v_s4;
	assign ctl.en_s3 = en_s3;
	assign ctl.en_s4 = en_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// Lanes 0..2 advance position by velocity, lanes 3..5 advance velocity by gravity.
	always_comb begin
		rate_w[0] = in_item.vel_x;
		rate_w[1] = in_item.vel_y;
		rate_w[2] = in_item.vel_z;
		rate_w[3] = gravity_x_q;
		rate_w[4] = gravity_y_q;
		rate_w[5] = gravity_z_q;
		base_w[0] = in_item.pos_x;
		base_w[1] = in_item.pos_y;
		base_w[2] = in_item.pos_z;
		base_w[3] = in_item.vel_x;
		base_w[4] = in_item.vel_y;
		base_w[5] = in_item.vel_z;
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int i = 0; i < LANES; i++) begin
				prod_s1[i] <= rate_w[i] * $signed({1'b0, in_item.delta_time});
				base_s1[i] <= base_w[i];
			end
		end
	end

	// The upper bits of the rounded product give the floor of the shift.
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			rnd_w[i] = prod_s1[i] + 49'sd32768;
			sum_w[i] = {{2{base_s1[i][31]}}, base_s1[i]} + {rnd_w[i][48], rnd_w[i][48:16]};
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			for (int i = 0; i < LANES; i++) begin
				res_s2[i] <= pewb_pkg::sat32({sum_w[i][33], sum_w[i]});
			end
		end
	end

	pewb_wall u_wall_x (
		.clk    (clk),
		.ctl    (ctl),
		.pos_s2 (res_s2[0]),
		.vel_s2 (res_s2[3]),
		.half   (scene_width_q[30:1]),
		.bounce (bounce_factor_q),
		.pos_s4 (pos_x_s4),
		.vel_s4 (vel_x_s4)
	);

	pewb_wall u_wall_z (
		.clk    (clk),
		.ctl    (ctl),
		.pos_s2 (res_s2[2]),
		.vel_s2 (res_s2[5]),
		.half   (scene_height_q[30:1]),
		.bounce (bounce_factor_q),
		.pos_s4 (pos_z_s4),
		.vel_s4 (vel_z_s4)
	);

	// Y has no walls; it only keeps pace with the other axes.
	always_ff @(posedge clk) begin
		if (en_s3) begin
			pos_y_s3 <= res_s2[1];
			vel_y_s3 <= res_s2[4];
		end
		if (en_s4) begin
			pos_y_s4 <= pos_y_s3;
			vel_y_s4 <= vel_y_s3;
		end
	end

	always_comb begin
		out_item.new_pos_x = pos_x_s4;
		out_item.new_pos_y = pos_y_s4;
		out_item.new_pos_z = pos_z_s4;
		out_item.new_vel_x = vel_x_s4;
		out_item.new_vel_y = vel_y_s4;
		out_item.new_vel_z = vel_z_s4;
	end

endmodule

`default_nettype wire

/* tb/particle_euler_step_wall_bounce_top_tb.sv */
// Self-checking testbench for the particle Euler step block with wall bounce.
`timescale 1ns / 1ps

module particle_euler_step_wall_bounce_top_tb;

	localparam logic signed [31:0] Q_MAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh80000000;
	localparam logic [pewb_pkg::CFG_IDX_W-1:0] REG_SPARE_LO =
		pewb_pkg::REG_BOUNCE_FACTOR + 1'b1;
	localparam logic [pewb_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = '1;
	localparam int NUM_PHASES = 10;
	localparam int ITEMS_PER_PHASE = 144;
	localparam int DRAIN_CYCLES = 12;
	localparam int CYCLE_LIMIT = 400000;
	localparam int REPORT_CAP = 200;

	// Holds a copy of the register file, predicts each particle step and checks results.
	class particle_step_ledger;
		logic [30:0] width_reg;
		logic [30:0] height_reg;
		logic signed [31:0] grav_x;
		logic signed [31:0] grav_y;
		logic signed [31:0] grav_z;
		logic [15:0] bounce_reg;
		pewb_pkg::out_item_t predicted_states[$];
		int fails;
		int checked;

		function new();
			width_reg = pewb_pkg::RST_SCENE_WIDTH;
			height_reg = pewb_pkg::RST_SCENE_HEIGHT;
			grav_x = pewb_pkg::RST_GRAVITY_X;
			grav_y = pewb_pkg::RST_GRAVITY_Y;
			grav_z = pewb_pkg::RST_GRAVITY_Z;
			bounce_reg = pewb_pkg::RST_BOUNCE_FACTOR;
			fails = 0;
			checked = 0;
		endfunction

		function void apply_write(logic [pewb_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
			case (idx)
				pewb_pkg::REG_SCENE_WIDTH: width_reg = data[30:0];
				pewb_pkg::REG_SCENE_HEIGHT: height_reg = data[30:0];
				pewb_pkg::REG_GRAVITY_X: grav_x = data;
				pewb_pkg::REG_GRAVITY_Y: grav_y = data;
				pewb_pkg::REG_GRAVITY_Z: grav_z = data;
				pewb_pkg::REG_BOUNCE_FACTOR: bounce_reg = data[15:0];
				default: ;
			endcase
		endfunction

		function longint clip(longint v);
			if (v > 64'sd2147483647) begin
				return 64'sd2147483647;
			end
			if (v < -64'sd2147483648) begin
				return -64'sd2147483648;
			end
			return v;
		endfunction

		// base + rate * dt, with the product rounded half up to Q20.12.
		function longint advance(longint base, longint rate, longint dt);
			return clip(base + ((rate * dt + 64'sd32768) >>> 16));
		endfunction

		function void hit_wall(inout longint p, inout longint v, input longint half);
			longint gain;
			gain = bounce_reg;
			if (p < -half || p > half) begin
				p = (p < -half) ? -half : half;
				v = clip(((-v) * gain + 64'sd16384) >>> 15);
			end
		endfunction

		function pewb_pkg::out_item_t predict_step(pewb_pkg::in_item_t it);
			longint px, py, pz, vx, vy, vz, dt, half_w, half_h;
			pewb_pkg::out_item_t r;
			dt = it.delta_time;
			half_w = width_reg >> 1;
			half_h = height_reg >> 1;
			px = advance(it.pos_x, it.vel_x, dt);
			py = advance(it.pos_y, it.vel_y, dt);
			pz = advance(it.pos_z, it.vel_z, dt);
			vx = advance(it.vel_x, grav_x, dt);
			vy = advance(it.vel_y, grav_y, dt);
			vz = advance(it.vel_z, grav_z, dt);
			hit_wall(px, vx, half_w);
			hit_wall(pz, vz, half_h);
			r.new_pos_x = px[31:0];
			r.new_pos_y = py[31:0];
			r.new_pos_z = pz[31:0];
			r.new_vel_x = vx[31:0];
			r.new_vel_y = vy[31:0];
			r.new_vel_z = vz[31:0];
			return r;
		endfunction

		function void note_particle(pewb_pkg::in_item_t it);
			predicted_states.push_back(predict_step(it));
		endfunction

		function int pending();
			return predicted_states.size();
		endfunction

		task report(string msg);
			fails++;
			if (fails <= REPORT_CAP) begin
				$display("mismatch: %s", msg);
			end
		endtask

		task compare_field(string field, logic [31:0] got, logic [31:0] want);
			if (got !== want) begin
				report($sformatf("result %0d %s: got %h, expected %h", checked, field, got, want));
			end
		endtask

		task check_particle(pewb_pkg::out_item_t got);
			pewb_pkg::out_item_t want;
			if (predicted_states.size() == 0) begin
				report($sformatf("result %0d arrived with nothing outstanding", checked));
				checked++;
				return;
			end
			want = predicted_states.pop_front();
			compare_field("new_pos_x", got.new_pos_x, want.new_pos_x);
			compare_field("new_pos_y", got.new_pos_y, want.new_pos_y);
			compare_field("new_pos_z", got.new_pos_z, want.new_pos_z);
			compare_field("new_vel_x", got.new_vel_x, want.new_vel_x);
			compare_field("new_vel_y", got.new_vel_y, want.new_vel_y);
			compare_field("new_vel_z", got.new_vel_z, want.new_vel_z);
			checked++;
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	pewb_pkg::in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	pewb_pkg::out_item_t out_item;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [pewb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	particle_step_ledger ledger;
	bit in_calm = 1'b0;
	bit out_calm = 1'b0;
	int unsigned cycle_count = 0;

	particle_euler_step_wall_bounce_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic int pick_gap(bit calm);
		return calm ? 0 : $urandom_range(0, 16);
	endfunction

	function automatic pewb_pkg::in_item_t make_particle(logic signed [31:0] px,
			logic signed [31:0] py, logic signed [31:0] pz, logic signed [31:0] vx,
			logic signed [31:0] vy, logic signed [31:0] vz, logic [15:0] dt);
		pewb_pkg::in_item_t it;
		it.pos_x = px;
		it.pos_y = py;
		it.pos_z = pz;
		it.vel_x = vx;
		it.vel_y = vy;
		it.vel_z = vz;
		it.delta_time = dt;
		return it;
	endfunction

	// Near a wall, inside the box, or anywhere in the 32-bit range.
	function automatic logic signed [31:0] rand_coord(longint half);
		longint c;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				c = $urandom_range(0, 6);
				c = c - 3 + half;
				if ($urandom_range(0, 1)) begin
					c = -c;
				end
			end
			4, 5, 6: begin
				c = $urandom_range(0, 2 * half);
				c = c - half;
			end
			default: c = $urandom;
		endcase
		return c[31:0];
	endfunction

	function automatic logic signed [31:0] rand_rate();
		longint r;
		case ($urandom_range(0, 9))
			0, 1, 2: r = $urandom_range(0, 1 << 20);
			3, 4, 5, 6: r = $urandom_range(0, 1 << 26);
			7, 8: r = $urandom;
			default: begin
				case ($urandom_range(0, 3))
					0: r = Q_MAX;
					1: r = Q_MIN;
					2: r = -1;
					default: r = 1;
				endcase
			end
		endcase
		if ($urandom_range(0, 1)) begin
			r = -r;
		end
		return r[31:0];
	endfunction

	function automatic logic [15:0] rand_dt();
		if ($urandom_range(0, 4) == 0) begin
			case ($urandom_range(0, 3))
				0: return 16'h0000;
				1: return 16'hFFFF;
				2: return 16'h0001;
				default: return 16'h8000;
			endcase
		end
		return 16'($urandom_range(0, 65535));
	endfunction

	function automatic pewb_pkg::in_item_t random_particle();
		longint half_w, half_h;
		half_w = ledger.width_reg >> 1;
		half_h = ledger.height_reg >> 1;
		return make_particle(rand_coord(half_w), rand_coord(half_w), rand_coord(half_h),
			rand_rate(), rand_rate(), rand_rate(), rand_dt());
	endfunction

	function automatic logic [31:0] rand_box();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 1 << 24);
			2: return $urandom_range(0, 1 << 14);
			default: return $urandom_range(1 << 20, 1 << 23);
		endcase
	endfunction

	function automatic logic [31:0] rand_gravity();
		longint g;
		case ($urandom_range(0, 4))
			0: g = $urandom;
			1, 2: begin
				g = $urandom_range(0, 1 << 23);
				if ($urandom_range(0, 1)) begin
					g = -g;
				end
			end
			3: g = 0;
			default: g = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
		endcase
		return g[31:0];
	endfunction

	function automatic logic [31:0] rand_bounce();
		case ($urandom_range(0, 3))
			0, 1: return $urandom_range(0, 32768);
			2: return $urandom;
			default: return $urandom_range(0, 1) ? 32'd65535 : 32'd0;
		endcase
	endfunction

	// Valid stays high between back-to-back items; it only drops when a gap is drawn.
	task automatic send_particle(input pewb_pkg::in_item_t it, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (!in_ready);
		ledger.note_particle(it);
		if ($urandom_range(0, 39) == 0) begin
			in_calm = ~in_calm;
		end
	endtask

	task automatic write_reg(input logic [pewb_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		ledger.apply_write(idx, data);
	endtask

	task automatic settle();
		while (ledger.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Result side: a random stall before each item, with calm stretches.
	initial begin
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = pick_gap(out_calm);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			ledger.check_particle(out_item);
			if ($urandom_range(0, 39) == 0) begin
				out_calm = ~out_calm;
			end
		end
	end

	initial begin
		pewb_pkg::in_item_t drills[$];
		logic signed [31:0] hw, hh;
		ledger = new();
		hw = 32'(pewb_pkg::RST_SCENE_WIDTH >> 1);
		hh = 32'(pewb_pkg::RST_SCENE_HEIGHT >> 1);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items against the reset configuration.
		drills.push_back(make_particle(0, 0, 0, 0, 0, 0, 16'h0000));
		drills.push_back(make_particle(0, 0, 0, 1, -1, 1, 16'h8000));
		drills.push_back(make_particle(0, 0, 0, -1, -1, -1, 16'h8000));
		drills.push_back(make_particle(hw, 0, hh, 0, 0, 0, 16'h0000));
		drills.push_back(make_particle(-hw, 0, -hh, 0, 0, 0, 16'h0000));
		drills.push_back(make_particle(hw + 1, 0, hh + 1, 4096, 0, 4096, 16'h0000));
		drills.push_back(make_particle(-hw - 1, 0, -hh - 1, -4096, 0, -4096, 16'h0000));
		drills.push_back(make_particle(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 16'hFFFF));
		drills.push_back(make_particle(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 16'hFFFF));
		drills.push_back(make_particle(0, Q_MIN, -hh - 100, 0, Q_MIN, Q_MIN, 16'h0000));
		drills.push_back(make_particle(Q_MAX, 0, 0, Q_MIN, 0, 0, 16'hFFFF));
		drills.push_back(make_particle(0, 0, 0, 0, 0, 0, 16'hFFFF));
		drills.push_back(make_particle(100 << 12, -5 << 12, 50 << 12, 200 << 12, 10 << 12,
			-30 << 12, 16'd655));
		drills.push_back(make_particle(hw - 10, 0, hh - 10, 1 << 20, 0, 1 << 20, 16'd1000));
		drills.push_back(make_particle(32'sh55555555, 32'shAAAAAAAA, 32'sh55555555,
			32'shAAAAAAAA, 32'sh55555555, 32'shAAAAAAAA, 16'hAAAA));
		foreach (drills[i]) begin
			send_particle(drills[i], pick_gap(in_calm));
		end

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			in_valid <= 1'b0;
			settle();
			case (phase)
				0: ;
				1: begin
					// Zero-sized box: nearly every particle hits both walls.
					write_reg(pewb_pkg::REG_SCENE_WIDTH, 32'd0);
					write_reg(pewb_pkg::REG_SCENE_HEIGHT, 32'd0);
					write_reg(pewb_pkg::REG_GRAVITY_X, Q_MAX);
					write_reg(pewb_pkg::REG_GRAVITY_Y, Q_MIN);
					write_reg(pewb_pkg::REG_GRAVITY_Z, 32'd0);
					write_reg(pewb_pkg::REG_BOUNCE_FACTOR, 32'd65535);
				end
				2: begin
					write_reg(pewb_pkg::REG_SCENE_WIDTH, 32'hFFFFFFFF);
					write_reg(pewb_pkg::REG_SCENE_HEIGHT, 32'h7FFFFFFF);
					write_reg(pewb_pkg::REG_GRAVITY_X, Q_MIN);
					write_reg(pewb_pkg::REG_GRAVITY_Y, Q_MAX);
					write_reg(pewb_pkg::REG_GRAVITY_Z, Q_MAX);
					write_reg(pewb_pkg::REG_BOUNCE_FACTOR, 32'd0);
				end
				3: begin
					// Odd box sizes, unity bounce.
					write_reg(pewb_pkg::REG_SCENE_WIDTH, $urandom_range(1, 1 << 16) | 32'd1);
					write_reg(pewb_pkg::REG_SCENE_HEIGHT, $urandom_range(1, 1 << 16) | 32'd1);
					write_reg(pewb_pkg::REG_GRAVITY_X, rand_gravity());
					write_reg(pewb_pkg::REG_GRAVITY_Z, rand_gravity());
					write_reg(pewb_pkg::REG_BOUNCE_FACTOR, 32'd32768);
				end
				4: begin
					// Writes to unused indexes must leave the registers alone.
					write_reg(pewb_pkg::REG_SCENE_WIDTH, rand_box());
					write_reg(REG_SPARE_LO, $urandom);
					write_reg(REG_SPARE_HI, $urandom);
					write_reg(pewb_pkg::REG_BOUNCE_FACTOR, rand_bounce());
					write_reg(REG_SPARE_LO, $urandom);
				end
				default: begin
					write_reg(pewb_pkg::REG_SCENE_WIDTH, rand_box());
					write_reg(pewb_pkg::REG_SCENE_HEIGHT, rand_box());
					write_reg(pewb_pkg::REG_GRAVITY_X, rand_gravity());
					write_reg(pewb_pkg::REG_GRAVITY_Y, rand_gravity());
					write_reg(pewb_pkg::REG_GRAVITY_Z, rand_gravity());
					write_reg(pewb_pkg::REG_BOUNCE_FACTOR, rand_bounce());
				end
			endcase
			cfg_valid <= 1'b0;
			repeat (ITEMS_PER_PHASE) begin
				send_particle(random_particle(), pick_gap(in_calm));
			end
		end

		in_valid <= 1'b0;
		settle();
		if (ledger.fails == 0 && ledger.pending() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
